FILE: hw/rtl/srps_pkg.sv
package srps_pkg;

  localparam int unsigned SpeedWidth = 13;
  localparam int unsigned ZoneWidth = 10;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned ReqSpeedWidth = 16;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth = 13;

  localparam logic [ZoneWidth-1:0] DeadzoneReset = 10'd15;
  localparam logic [SpeedWidth-1:0] LimitReset = 13'd6000;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEADZONE = 1'b0,
    REG_LIMIT    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_MANUAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TO_LOW    = 3'd1,
    PH_HOLD_LOW  = 3'd2,
    PH_TO_HIGH   = 3'd3,
    PH_HOLD_HIGH = 3'd4,
    PH_FINISH    = 3'd5,
    PH_STOPPING  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [TimeWidth-1:0]      now_ms;
    logic                      coater_idle;
    logic [SpeedWidth-1:0]     measured_rpm;
    logic [ReqSpeedWidth-1:0]  manual_rpm;
    logic [ReqSpeedWidth-1:0]  low_rpm;
    logic [ReqSpeedWidth-1:0]  high_rpm;
    logic [TimeWidth-1:0]      low_hold_ms;
    logic [TimeWidth-1:0]      high_hold_ms;
  } req_t;

  typedef struct packed {
    logic [ZoneWidth-1:0]  deadzone;
    logic [SpeedWidth-1:0] limit;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [TimeWidth-1:0]  hold_start_ms;
    logic [SpeedWidth-1:0] low_rpm;
    logic [SpeedWidth-1:0] high_rpm;
    logic [TimeWidth-1:0]  low_hold;
    logic [TimeWidth-1:0]  high_hold;
  } seq_state_t;

  typedef struct packed {
    cmd_t                  ramp_command;
    logic [SpeedWidth-1:0] ramp_goal_rpm;
    logic                  target_written;
    logic [SpeedWidth-1:0] target_value;
    logic                  motor_stop;
    logic                  finish_notice;
    phase_t                phase;
  } result_t;

endpackage

FILE: hw/rtl/spin_ramp_profile_sequencer.sv
// Motor speed profile sequencer.
// Requests enter on in_valid/in_stall, one operation each: tick, profile start,
// profile stop or manual target. Every request yields exactly one result on
// out_valid/out_stall carrying the ramp command, the manual target write, the
// stop and finish flags and the phase after the request.
// A request is captured in an input register; the sequencer logic then
// evaluates it against the stored profile state and loads the result register.
// One request is taken per cycle while the receiver does not stall. The state
// update and the result load share one clock edge, so each request sees the
// state left by the previous one.
// When the receiver stalls, the result register holds; one more request may wait
// in the input register, after which in_stall rises until the result is taken.
// The configuration registers (deadzone, speed limit) are written through
// cfg_wen/cfg_index/cfg_data and take effect at once.
// Synchronous reset empties both registers, sets the phase to idle, clears the
// stored profile and restores deadzone 15 and speed limit 6000.
module spin_ramp_profile_sequencer
  import srps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [TimeWidth-1:0]     now_ms,
  input  logic                     coater_idle,
  input  logic [SpeedWidth-1:0]    measured_rpm,
  input  logic [ReqSpeedWidth-1:0] manual_rpm,
  input  logic [ReqSpeedWidth-1:0] low_rpm,
  input  logic [ReqSpeedWidth-1:0] high_rpm,
  input  logic [TimeWidth-1:0]     low_hold_ms,
  input  logic [TimeWidth-1:0]     high_hold_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               ramp_command,
  output logic [SpeedWidth-1:0]    ramp_goal_rpm,
  output logic                     target_written,
  output logic [SpeedWidth-1:0]    target_value,
  output logic                     motor_stop,
  output logic                     finish_notice,
  output logic [2:0]               phase
);

  cfg_t       cfg;
  req_t       req;
  logic       in_full;
  seq_state_t state;
  seq_state_t state_next;
  result_t    result_next;
  result_t    result;
  logic       advance;
  logic       accept;

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone <= DeadzoneReset;
      cfg.limit <= LimitReset;
    end else if (cfg_wen) begin
      case (reg_index_t'(cfg_index))
        REG_DEADZONE: cfg.deadzone <= cfg_data[ZoneWidth-1:0];
        REG_LIMIT:    cfg.limit <= cfg_data[SpeedWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.operation <= operation;
      req.now_ms <= now_ms;
      req.coater_idle <= coater_idle;
      req.measured_rpm <= measured_rpm;
      req.manual_rpm <= manual_rpm;
      req.low_rpm <= low_rpm;
      req.high_rpm <= high_rpm;
      req.low_hold_ms <= low_hold_ms;
      req.high_hold_ms <= high_hold_ms;
    end
  end

  srps_step u_step (
    .state      (state),
    .req        (req),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  // The idle phase code is zero, so clearing the whole state selects it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign ramp_command = result.ramp_command;
  assign ramp_goal_rpm = result.ramp_goal_rpm;
  assign target_written = result.target_written;
  assign target_value = result.target_value;
  assign motor_stop = result.motor_stop;
  assign finish_notice = result.finish_notice;
  assign phase = result.phase;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finish_notice) |-> (motor_stop && (phase == PH_IDLE)))
    else $error("finish notice without motor stop to idle");

  a_no_cmd_no_goal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (ramp_command == CMD_NONE)) |-> (ramp_goal_rpm == '0))
    else $error("ramp goal set without a ramp command");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated request produced no result");
`endif

endmodule

FILE: hw/rtl/srps_step.sv
module srps_step
  import srps_pkg::*;
(
  input  seq_state_t state,
  input  req_t       req,
  input  cfg_t       cfg,
  output seq_state_t state_next,
  output result_t    result
);

  logic                  busy;
  logic                  hold_low_done;
  logic                  hold_high_done;
  logic [TimeWidth-1:0]  elapsed;
  logic [SpeedWidth-1:0] lo_clamp;
  logic [SpeedWidth-1:0] hi_clamp;
  logic [SpeedWidth-1:0] man_clamp;
  logic [SpeedWidth-1:0] lo_sorted;
  logic [SpeedWidth-1:0] hi_sorted;
  logic [TimeWidth-1:0]  low_hold_fix;
  logic [TimeWidth-1:0]  high_hold_fix;
  logic [SpeedWidth:0]   meas_plus_dz;
  logic [SpeedWidth:0]   target_plus_dz;

  function automatic logic [SpeedWidth-1:0] clamp_speed(
    input logic [ReqSpeedWidth-1:0] v,
    input logic [SpeedWidth-1:0]    limit
  );
    logic [SpeedWidth-1:0] r;
    if (v[ReqSpeedWidth-1]) begin
      r = '0;
    end else if (v[ReqSpeedWidth-2:0] > {2'b00, limit}) begin
      r = limit;
    end else begin
      r = v[SpeedWidth-1:0];
    end
    return r;
  endfunction

  assign busy = (state.phase == PH_TO_LOW) || (state.phase == PH_HOLD_LOW) ||
                (state.phase == PH_TO_HIGH) || (state.phase == PH_HOLD_HIGH) ||
                (state.phase == PH_FINISH) || (state.phase == PH_STOPPING);

  assign elapsed = req.now_ms - state.hold_start_ms;
  assign hold_low_done = elapsed >= state.low_hold;
  assign hold_high_done = elapsed >= state.high_hold;

  assign lo_clamp = clamp_speed(req.low_rpm, cfg.limit);
  assign hi_clamp = clamp_speed(req.high_rpm, cfg.limit);
  assign man_clamp = clamp_speed(req.manual_rpm, cfg.limit);
  assign lo_sorted = (lo_clamp > hi_clamp) ? hi_clamp : lo_clamp;
  assign hi_sorted = (lo_clamp > hi_clamp) ? lo_clamp : hi_clamp;
  assign low_hold_fix = (req.low_hold_ms == '0) ? TimeWidth'(1) : req.low_hold_ms;
  assign high_hold_fix = (req.high_hold_ms == '0) ? TimeWidth'(1) : req.high_hold_ms;

  assign meas_plus_dz = {1'b0, req.measured_rpm} + (SpeedWidth+1)'(cfg.deadzone);
  assign target_plus_dz = {1'b0, man_clamp} + (SpeedWidth+1)'(cfg.deadzone);

  always_comb begin
    state_next = state;
    case (op_t'(req.operation))
      OP_TICK: begin
        case (state.phase)
          PH_TO_LOW: begin
            if (req.coater_idle) begin
              state_next.phase = PH_HOLD_LOW;
              state_next.hold_start_ms = req.now_ms;
            end
          end
          PH_HOLD_LOW: begin
            if (hold_low_done) begin
              state_next.phase = PH_TO_HIGH;
            end
          end
          PH_TO_HIGH: begin
            if (req.coater_idle) begin
              state_next.phase = PH_HOLD_HIGH;
              state_next.hold_start_ms = req.now_ms;
            end
          end
          PH_HOLD_HIGH: begin
            if (hold_high_done) begin
              state_next.phase = PH_FINISH;
            end
          end
          PH_FINISH, PH_STOPPING: begin
            if (req.coater_idle) begin
              state_next.phase = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      OP_START: begin
        if (!busy) begin
          state_next.phase = PH_TO_LOW;
          state_next.low_rpm = lo_sorted;
          state_next.high_rpm = hi_sorted;
          state_next.low_hold = low_hold_fix;
          state_next.high_hold = high_hold_fix;
        end
      end
      OP_STOP: begin
        if (busy) begin
          state_next.phase = PH_STOPPING;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result = '0;
    result.ramp_command = CMD_NONE;
    case (op_t'(req.operation))
      OP_TICK: begin
        case (state.phase)
          PH_HOLD_LOW: begin
            if (hold_low_done) begin
              result.ramp_command = CMD_UP;
              result.ramp_goal_rpm = state.high_rpm;
            end
          end
          PH_HOLD_HIGH: begin
            if (hold_high_done) begin
              result.ramp_command = CMD_DOWN;
            end
          end
          PH_FINISH: begin
            if (req.coater_idle) begin
              result.motor_stop = 1'b1;
              result.finish_notice = 1'b1;
            end
          end
          PH_STOPPING: begin
            if (req.coater_idle) begin
              result.motor_stop = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_START: begin
        if (!busy) begin
          result.ramp_command = CMD_UP;
          result.ramp_goal_rpm = lo_sorted;
        end
      end
      OP_STOP: begin
        if (busy) begin
          result.ramp_command = CMD_DOWN;
        end
      end
      default: begin
        if (!busy) begin
          result.target_written = 1'b1;
          result.target_value = man_clamp;
          if (req.coater_idle) begin
            if ({1'b0, man_clamp} > meas_plus_dz) begin
              result.ramp_command = CMD_UP;
              result.ramp_goal_rpm = man_clamp;
            end else if ({1'b0, req.measured_rpm} > target_plus_dz) begin
              result.ramp_command = CMD_DOWN;
              result.ramp_goal_rpm = man_clamp;
            end
          end
        end
      end
    endcase
    result.phase = state_next.phase;
  end

endmodule
